// ===== design/dtsn_pkg.sv =====
// Shared definitions for the decimal text to scaled number block.
// Holds the default widths, the result exponent range and the control word
// that the top level hands to the parser. No dependencies.
package dtsn_pkg;

    localparam int MANTISSA_BITS_DEF = 64;
    localparam int COUNT_BITS_DEF    = 12;

    // The exponent field of a result is fixed at 14 bits, signed.
    localparam int EXP_BITS = 14;
    localparam int EXP_MAX  = 8191;
    localparam int EXP_MIN  = -8192;

    // Per-cycle control from the handshake stage to the parser.
    typedef struct packed {
        logic advance;  // a buffered character is consumed this cycle
        logic last;     // that character ends the text
    } t_step_ctrl;

endpackage

// ===== design/decimal_text_to_scaled_number.sv =====
// The word with tlast is taken into the input buffer, and the parse step then
// writes the result word into the result register, provided the result slot
// is free.
// Throughput: one character word per cycle unless a stalled result blocks;
// the parse step is a single multiply-by-ten add on the mantissa and exponent
// accumulators. A stalled result holds a buffered tlast word, and input stops.
// Reset (synchronous, active low) empties both registers and the parser.
module decimal_text_to_scaled_number #(
    parameter int MANTISSA_BITS = dtsn_pkg::MANTISSA_BITS_DEF,
    parameter int COUNT_BITS    = dtsn_pkg::COUNT_BITS_DEF,
    localparam int OUT_BITS     = MANTISSA_BITS + dtsn_pkg::EXP_BITS + 2,
    localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // char_code
    input  logic             s_axis_tlast,   // end_of_text
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // negative, mantissa, decimal_exponent,
                                             // saturated, zero fill
);

    logic                            r_in_valid;
    logic [7:0]                      r_char;
    logic                            r_last;
    logic                            r_out_valid;
    logic [OUT_W-1:0]                r_out_data, n_out_data;
    logic                            advance;
    dtsn_pkg::t_step_ctrl            ctrl;
    logic                            res_negative;
    logic [MANTISSA_BITS-1:0]        res_mantissa;
    logic [dtsn_pkg::EXP_BITS-1:0]   res_exponent;
    logic                            res_saturated;

    // A buffered word moves on unless it ends a text and the result slot is
    // still occupied.
    assign advance       = r_in_valid && (!r_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign ctrl.advance  = advance;
    assign ctrl.last     = r_last;

    dtsn_parser #(
        .MANTISSA_BITS (MANTISSA_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_char      (r_char),
        .o_negative  (res_negative),
        .o_mantissa  (res_mantissa),
        .o_exponent  (res_exponent),
        .o_saturated (res_saturated)
    );

    always_comb begin
        n_out_data = '0;
        n_out_data[0] = res_negative;
        n_out_data[MANTISSA_BITS:1] = res_mantissa;
        n_out_data[MANTISSA_BITS+dtsn_pkg::EXP_BITS:MANTISSA_BITS+1] = res_exponent;
        n_out_data[OUT_BITS-1] = res_saturated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            r_out_valid <= (advance && r_last) || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
        if (advance && r_last) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_last && r_out_valid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(advance && r_last))
        else $error("result appeared without an end-of-text word");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(advance && r_last))
        else $error("pending result would be overwritten");

endmodule

// ===== design/dtsn_parser.sv =====
// Character parser: holds the parse state and accumulators, consumes one
// character per cycle while advanced and presents the finished result of the current step.
// Depends on dtsn_pkg.
module dtsn_parser #(
    parameter int MANTISSA_BITS = dtsn_pkg::MANTISSA_BITS_DEF,
    parameter int COUNT_BITS    = dtsn_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dtsn_pkg::t_step_ctrl              i_ctrl,
    input  logic [7:0]                        i_char,
    output logic                              o_negative,
    output logic [MANTISSA_BITS-1:0]          o_mantissa,
    output logic [dtsn_pkg::EXP_BITS-1:0]     o_exponent,
    output logic                              o_saturated
);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_INT,
        PH_FRAC,
        PH_ESIGN,
        PH_EDIG,
        PH_DONE
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic                     r_sign, n_sign;
    logic [MANTISSA_BITS-1:0] r_mant, n_mant;
    logic [COUNT_BITS-1:0]    r_frac, n_frac;
    logic                     r_esign, n_esign;
    logic [COUNT_BITS-1:0]    r_eacc, n_eacc;
    logic                     r_ovf, n_ovf;

    logic                     is_digit;
    logic                     is_space;
    logic                     is_elet;
    logic [3:0]               digit;
    logic [MANTISSA_BITS+3:0] mant_ext;
    logic [MANTISSA_BITS-1:0] mant_step;
    logic                     mant_ovf;
    logic [COUNT_BITS+3:0]    eacc_ext;
    logic [COUNT_BITS-1:0]    eacc_step;
    logic                     eacc_ovf;
    logic [COUNT_BITS-1:0]    frac_step;
    logic                     frac_ovf;
    logic                     proceed;
    t_phase                   work_phase;
    logic signed [COUNT_BITS+1:0] exp_s;
    logic signed [31:0]       exp_wide;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_space = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign is_elet  = (i_char == CH_E_LO) || (i_char == CH_E_UP);
    assign digit    = is_digit ? 4'(i_char - CH_ZERO) : 4'd0;

    // Times ten as two shifts; anything above the top bit means the value
    // would pass the largest mantissa.
    assign mant_ext  = ({4'b0, r_mant} << 3) + ({4'b0, r_mant} << 1)
                     + (MANTISSA_BITS+4)'(digit);
    assign mant_ovf  = |mant_ext[MANTISSA_BITS+3:MANTISSA_BITS];
    assign mant_step = mant_ovf ? '1 : mant_ext[MANTISSA_BITS-1:0];

    assign eacc_ext  = ({4'b0, r_eacc} << 3) + ({4'b0, r_eacc} << 1)
                     + (COUNT_BITS+4)'(digit);
    assign eacc_ovf  = |eacc_ext[COUNT_BITS+3:COUNT_BITS];
    assign eacc_step = eacc_ovf ? '1 : eacc_ext[COUNT_BITS-1:0];

    assign frac_ovf  = &r_frac;
    assign frac_step = frac_ovf ? r_frac : r_frac + COUNT_BITS'(1);

    always_comb begin
        n_phase    = r_phase;
        n_sign     = r_sign;
        n_mant     = r_mant;
        n_frac     = r_frac;
        n_esign    = r_esign;
        n_eacc     = r_eacc;
        n_ovf      = r_ovf;
        proceed    = 1'b1;
        work_phase = r_phase;

        // The first non-blank character is either a sign, consumed here, or
        // falls through to the integer phase in the same cycle.
        if (r_phase == PH_SPACE) begin
            if (is_space) begin
                proceed = 1'b0;
            end else begin
                n_phase = PH_INT;
                if (i_char == CH_MINUS) begin
                    n_sign  = 1'b1;
                    proceed = 1'b0;
                end else if (i_char == CH_PLUS) begin
                    proceed = 1'b0;
                end else begin
                    work_phase = PH_INT;
                end
            end
        end

        if (proceed) begin
            case (work_phase)
                PH_INT: begin
                    if (is_digit) begin
                        n_mant = mant_step;
                        n_ovf  = r_ovf | mant_ovf;
                    end else if (i_char == CH_POINT) begin
                        n_phase = PH_FRAC;
                    end else if (is_elet) begin
                        n_phase = PH_ESIGN;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (is_digit) begin
                        n_mant = mant_step;
                        n_frac = frac_step;
                        n_ovf  = r_ovf | mant_ovf | frac_ovf;
                    end else if (is_elet) begin
                        n_phase = PH_ESIGN;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_ESIGN: begin
                    if (i_char == CH_MINUS) begin
                        n_esign = 1'b1;
                        n_phase = PH_EDIG;
                    end else if (i_char == CH_PLUS) begin
                        n_phase = PH_EDIG;
                    end else if (is_digit) begin
                        n_eacc  = eacc_step;
                        n_ovf   = r_ovf | eacc_ovf;
                        n_phase = PH_EDIG;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_EDIG: begin
                    if (is_digit) begin
                        n_eacc = eacc_step;
                        n_ovf  = r_ovf | eacc_ovf;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Net exponent from the state after this character.
    always_comb begin
        exp_s = n_esign ? -$signed({2'b00, n_eacc}) : $signed({2'b00, n_eacc});
        exp_s = exp_s - $signed({2'b00, n_frac});
        exp_wide    = 32'(exp_s);
        o_saturated = n_ovf;
        if (exp_wide > dtsn_pkg::EXP_MAX) begin
            exp_wide    = dtsn_pkg::EXP_MAX;
            o_saturated = 1'b1;
        end else if (exp_wide < dtsn_pkg::EXP_MIN) begin
            exp_wide    = dtsn_pkg::EXP_MIN;
            o_saturated = 1'b1;
        end
        o_exponent = exp_wide[dtsn_pkg::EXP_BITS-1:0];
    end

    assign o_negative = n_sign;
    assign o_mantissa = n_mant;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctrl.advance && i_ctrl.last)) begin
            r_phase <= PH_SPACE;
            r_sign  <= 1'b0;
            r_mant  <= '0;
            r_frac  <= '0;
            r_esign <= 1'b0;
            r_eacc  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_phase <= n_phase;
            r_sign  <= n_sign;
            r_mant  <= n_mant;
            r_frac  <= n_frac;
            r_esign <= n_esign;
            r_eacc  <= n_eacc;
            r_ovf   <= n_ovf;
        end
    end

    // Nothing is accumulated while still skipping blanks.
    a_space_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SPACE) |-> (r_mant == '0 && r_frac == '0 && r_eacc == '0
                                   && !r_sign && !r_ovf))
        else $error("accumulators not clear in blank phase");

    // The word that ends a text leaves the parser in its reset state.
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.advance && i_ctrl.last) |=> (r_phase == PH_SPACE && !r_esign))
        else $error("parser not reset after end of text");

endmodule

// ===== bench/decimal_text_to_scaled_number_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for decimal_text_to_scaled_number: character words in,
// scaled number words out, checked against a scoreboard that parses the same
// text. Depends on dtsn_pkg and the block itself.
module decimal_text_to_scaled_number_tb;

    localparam int MANT_BITS = dtsn_pkg::MANTISSA_BITS_DEF;
    localparam int CNT_BITS  = dtsn_pkg::COUNT_BITS_DEF;
    localparam int EXP_BITS  = dtsn_pkg::EXP_BITS;
    localparam int OUT_W     = ((MANT_BITS + EXP_BITS + 2 + 7) / 8) * 8;

    localparam logic [MANT_BITS-1:0] MANT_MAX = '1;
    localparam logic [CNT_BITS-1:0]  CNT_MAX  = '1;

    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_POINT = ".";
    localparam logic [7:0] CH_E_LO  = "e";
    localparam logic [7:0] CH_E_UP  = "E";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    localparam int RANDOM_CHARS = 1425;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 300;
    localparam int CALM_FROM    = 600;
    localparam int CALM_TO      = 900;
    localparam int IDLE_PCT     = 21;

    typedef enum logic [2:0] {
        PH_SPACE, PH_INT, PH_FRAC, PH_ESIGN, PH_EDIG, PH_DONE
    } t_parse_phase;

    // Same layout as m_axis_tdata, lowest field last in the list.
    typedef struct packed {
        logic                 saturated;
        logic [EXP_BITS-1:0]  exponent;
        logic [MANT_BITS-1:0] mantissa;
        logic                 negative;
    } t_scaled_number;

    class t_number_scoreboard;
        t_parse_phase         phase;
        logic                 negative;
        logic [MANT_BITS-1:0] digits;
        logic [CNT_BITS-1:0]  frac_count;
        logic                 exp_negative;
        logic [CNT_BITS-1:0]  exp_value;
        logic                 overflow;
        t_scaled_number       expected_numbers[$];
        int                   errors;
        int                   checked;
        int                   saturated_seen;

        function new();
            errors = 0;
            checked = 0;
            saturated_seen = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_SPACE;
            negative = 1'b0;
            digits = '0;
            frac_count = '0;
            exp_negative = 1'b0;
            exp_value = '0;
            overflow = 1'b0;
        endfunction

        function int pending();
            return expected_numbers.size();
        endfunction

        function void add_mantissa_digit(logic [3:0] d);
            if (digits > (MANT_MAX - MANT_BITS'(d)) / 10) begin
                digits = MANT_MAX;
                overflow = 1'b1;
            end else begin
                digits = digits * 10 + MANT_BITS'(d);
            end
        endfunction

        function void add_exponent_digit(logic [3:0] d);
            int nv;
            nv = int'(exp_value) * 10 + int'(d);
            if (nv > int'(CNT_MAX)) begin
                exp_value = CNT_MAX;
                overflow = 1'b1;
            end else begin
                exp_value = CNT_BITS'(nv);
            end
        endfunction

        function void parse_char(logic [7:0] c);
            logic       is_dig;
            logic       is_exp;
            logic [3:0] d;
            is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
            d = is_dig ? 4'(c - CH_ZERO) : 4'd0;
            is_exp = (c == CH_E_LO) || (c == CH_E_UP);
            if (phase == PH_SPACE) begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
                phase = PH_INT;
                if (c == CH_MINUS) begin
                    negative = 1'b1;
                    return;
                end
                if (c == CH_PLUS) return;
            end
            case (phase)
                PH_INT: begin
                    if (is_dig) add_mantissa_digit(d);
                    else if (c == CH_POINT) phase = PH_FRAC;
                    else if (is_exp) phase = PH_ESIGN;
                    else phase = PH_DONE;
                end
                PH_FRAC: begin
                    if (is_dig) begin
                        add_mantissa_digit(d);
                        if (frac_count == CNT_MAX) overflow = 1'b1;
                        else frac_count = frac_count + 1'b1;
                    end else if (is_exp) begin
                        phase = PH_ESIGN;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_ESIGN: begin
                    if (c == CH_MINUS) begin
                        exp_negative = 1'b1;
                        phase = PH_EDIG;
                    end else if (c == CH_PLUS) begin
                        phase = PH_EDIG;
                    end else if (is_dig) begin
                        add_exponent_digit(d);
                        phase = PH_EDIG;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_EDIG: begin
                    if (is_dig) add_exponent_digit(d);
                    else phase = PH_DONE;
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted character word.
        function void accept_char(logic [7:0] c, logic last);
            int             e;
            t_scaled_number r;
            parse_char(c);
            if (!last) return;
            e = exp_negative ? -int'(exp_value) : int'(exp_value);
            e = e - int'(frac_count);
            r.saturated = overflow;
            if (e > dtsn_pkg::EXP_MAX) begin
                e = dtsn_pkg::EXP_MAX;
                r.saturated = 1'b1;
            end else if (e < dtsn_pkg::EXP_MIN) begin
                e = dtsn_pkg::EXP_MIN;
                r.saturated = 1'b1;
            end
            r.negative = negative;
            r.mantissa = digits;
            r.exponent = e[EXP_BITS-1:0];
            expected_numbers.push_back(r);
            clear();
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            t_scaled_number got;
            t_scaled_number want;
            got = t_scaled_number'(data);
            if (expected_numbers.size() == 0) begin
                $error("unexpected result word %h", data);
                errors++;
                return;
            end
            want = expected_numbers.pop_front();
            checked++;
            if (got.saturated) saturated_seen++;
            if (got.negative !== want.negative) begin
                $error("negative: expected %0d, got %0d", want.negative, got.negative);
                errors++;
            end
            if (got.mantissa !== want.mantissa) begin
                $error("mantissa: expected %0d, got %0d", want.mantissa, got.mantissa);
                errors++;
            end
            if (got.exponent !== want.exponent) begin
                $error("decimal_exponent: expected %0d, got %0d",
                       $signed(want.exponent), $signed(got.exponent));
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = 8'd0;   // char_code
    logic             s_axis_tlast = 1'b0;   // end_of_text
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;          // negative, mantissa, decimal_exponent,
                                             // saturated, zero fill

    t_number_scoreboard numbers = new();

    logic [7:0] text_chars[$];
    int         chars_accepted = 0;
    int         texts_sent = 0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;

    decimal_text_to_scaled_number i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit calm_window();
        return chars_accepted >= CALM_FROM && chars_accepted < CALM_TO;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Entered and left at a falling edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        while (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        numbers.accept_char(c, last);
        chars_accepted++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_chars.size(); i++) begin
            send_char(text_chars[i], i == text_chars.size() - 1);
        end
        texts_sent++;
    endtask

    task automatic send_string(input string s);
        text_chars.delete();
        for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
        send_text();
    endtask

    task automatic build_well_formed();
        int n;
        text_chars.delete();
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) begin
            n = $urandom_range(8, 13);
            text_chars.push_back(n == 8 ? CH_SPACE : 8'(n));
        end
        case ($urandom_range(0, 3))
            0: text_chars.push_back(CH_MINUS);
            1: text_chars.push_back(CH_PLUS);
            default: ;
        endcase
        // Now and then enough digits to run the mantissa into saturation.
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 6);
        repeat (n) text_chars.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
            text_chars.push_back(CH_POINT);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 5);
            repeat (n) text_chars.push_back(rand_digit());
        end
        if ($urandom_range(0, 1)) begin
            text_chars.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
            case ($urandom_range(0, 2))
                0: text_chars.push_back(CH_MINUS);
                1: text_chars.push_back(CH_PLUS);
                default: ;
            endcase
            n = $urandom_range(0, 4);
            repeat (n) text_chars.push_back(rand_digit());
        end
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 2);
            repeat (n) text_chars.push_back(8'($urandom_range(0, 255)));
        end
        if (text_chars.size() == 0) text_chars.push_back(8'($urandom_range(0, 255)));
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off while the
    // sender keeps offering words.
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && chars_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) numbers.check_result(m_axis_tdata);
    end

    initial begin : watchdog
        #5_000_000;
        $display("decimal_text_to_scaled_number_tb failed");
        $finish;
    end

    initial begin : text_source
        int random_chars;
        int kind;
        int pos;
        random_chars = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed texts: whitespace, signs, fraction, exponent forms, a sign
        // with no exponent letter, no digits, exponent saturation, and the
        // extreme character codes.
        send_string(" -1.5e-3");
        send_string("+e5");
        send_string("4-2");
        send_string("7E12");
        send_string("e9999");
        text_chars.delete();
        text_chars.push_back(8'hFF);
        send_text();
        text_chars.delete();
        text_chars.push_back(8'h00);
        send_text();

        while (random_chars < RANDOM_CHARS) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                build_well_formed();
            end else if (kind < 88) begin
                build_well_formed();
                pos = $urandom_range(0, text_chars.size() - 1);
                text_chars[pos] = 8'($urandom_range(0, 255));
            end else begin
                text_chars.delete();
                repeat ($urandom_range(1, 6)) text_chars.push_back(8'($urandom_range(0, 255)));
            end
            random_chars += text_chars.size();
            send_text();
            // Let the block drain completely once mid-run.
            if (texts_sent == 60) begin
                do begin
                    s_axis_tvalid <= 1'b0;
                    @(negedge i_clk);
                end while (numbers.pending() != 0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (numbers.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("Sent %0d texts in %0d character words; checked %0d results, %0d saturated.",
                 texts_sent, chars_accepted, numbers.checked, numbers.saturated_seen);
        if (numbers.errors == 0 && numbers.pending() == 0) begin
            $display("decimal_text_to_scaled_number_tb passed");
        end else begin
            $display("decimal_text_to_scaled_number_tb failed");
        end
        $finish;
    end

endmodule
